// ----- hdl/asmf_pkg.sv -----
// Package for the ADC supply monitor filter: payload structs, divider
// request/response structs, register indexes and fixed constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package asmf_pkg;

  // One ADC frame in
  typedef struct packed {
    logic signed [15:0] cin_raw;
    logic        [15:0] vin_raw;
    logic        [15:0] vaux_raw;
    logic        [15:0] vcore_raw;
    logic        [15:0] vrefint_raw;
  } in_t;

  // One result frame out
  typedef struct packed {
    logic        [15:0] vcc_mv;
    logic        [15:0] vin_mv;
    logic        [15:0] vaux_mv;
    logic        [15:0] vcore_mv;
    logic signed [15:0] cin_ma;
  } out_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_KVREFCAL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VIN_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VAUX_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VCORE_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CIN_GAIN_X4 = 3'd4;

  // Register reset values
  localparam logic [31:0] KVREFCAL_RST    = 32'd3999600;
  localparam logic [7:0]  VIN_GAIN_RST    = 8'd18;
  localparam logic [7:0]  VAUX_GAIN_RST   = 8'd2;
  localparam logic [7:0]  VCORE_GAIN_RST  = 8'd1;
  localparam logic [7:0]  CIN_GAIN_X4_RST = 8'd10;

  // Nominal supply, used for the reference history reset and a zero average
  localparam logic [15:0] NOMINAL_MV = 16'd3300;

  // Width of one scaled current sample (signed)
  localparam int unsigned CUR_W = 22;

  // Shared divider: 32-bit dividend, 16-bit divisor, two quotient bits a cycle
  localparam int unsigned DIV_W      = 32;
  localparam int unsigned DSR_W      = 16;
  localparam int unsigned DIV_RADIX  = 2;
  localparam int unsigned DIV_STEPS  = DIV_W / DIV_RADIX;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- hdl/asmf_div.sv -----
// Iterative restoring divider shared by the reference average, supply and current average steps.
// Depends on asmf_pkg for widths and the request/response structs.
`timescale 1ns / 1ps
`default_nettype none

module asmf_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire asmf_pkg::div_req_t req_i,
  output asmf_pkg::div_rsp_t     rsp_o
);

  logic                            busy_q;
  logic                            done_q;
  logic [asmf_pkg::DIV_CNT_W-1:0]  cnt_q;
  logic [asmf_pkg::DIV_W-1:0]      dvd_q, dvd_d;
  logic [asmf_pkg::DSR_W-1:0]      rem_q, rem_d;
  logic [asmf_pkg::DSR_W-1:0]      dsr_q;

  // Radix-4 step: two restoring iterations on the partial remainder
  always_comb begin
    logic [asmf_pkg::DSR_W:0] trial;
    dvd_d = dvd_q;
    rem_d = rem_q;
    for (int k = 0; k < asmf_pkg::DIV_RADIX; k++) begin
      trial = {rem_d, dvd_d[asmf_pkg::DIV_W-1]};
      dvd_d = {dvd_d[asmf_pkg::DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr_q}) begin
        trial    = trial - {1'b0, dsr_q};
        dvd_d[0] = 1'b1;
      end
      rem_d = trial[asmf_pkg::DSR_W-1:0];
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == asmf_pkg::DIV_CNT_W'(asmf_pkg::DIV_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Operands and partial results
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      rem_q <= '0;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

  // A new division never starts on top of one in flight
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");

  // The last step always raises done
  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !req_i.start &&
    (cnt_q == asmf_pkg::DIV_CNT_W'(asmf_pkg::DIV_STEPS - 1)) |=> done_q && !busy_q)
    else $error("divider did not finish after its last step");

  // Done is a single-cycle pulse
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && !req_i.start |=> !done_q)
    else $error("divider done held longer than one cycle");

endmodule

`default_nettype wire

// ----- hdl/asmf_hist.sv -----
// History memory for one running average: one write port, one registered
// read port, and reset-value substitution until the ring has filled once.
// No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module asmf_hist #(
  parameter int unsigned DEPTH   = 128,
  parameter int unsigned WIDTH   = 16,
  parameter logic [WIDTH-1:0] RST_VAL = '0,
  parameter int unsigned ADDR_W  = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] addr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              filled_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_q;

  // Write and registered read at the same slot address
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rd_q <= mem_q[addr_i];
  end

  // Entries not yet written since reset read as the reset value
  assign rdata_o = filled_i ? rd_q : RST_VAL;

endmodule

`default_nettype wire

// ----- hdl/adc_supply_monitor_filter.sv -----
// Top level of the ADC supply monitor filter: sequencer, config registers,
// shared multiplier, running sums. Uses asmf_pkg, asmf_div and asmf_hist.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one ADC frame
//   per transaction. Output channel (out_valid_o / out_stall_i / out_data_o)
//   returns one result frame per input frame, in order.
//   A frame is taken only while the sequencer is idle; each frame then runs
//   up to three passes through the shared radix-4 divider (reference
//   average, supply, current average; no supply pass when the reference
//   average is zero) and a gain and a supply-scaling product per channel
//   on the shared 24x16 multiplier. A new frame is taken in the cycle after
//   its predecessor's result is loaded into the output register.
//   The result sits in an output register: the next frame is accepted while
//   it waits. If the receiver still stalls when the next result is ready,
//   the sequencer holds that result until the output register frees up.
//   Reset returns the registers to their defaults, the reference history to
//   3300 per entry and the current history to zero; no clearing pass runs,
//   so the block can take a frame as soon as reset is released.
//   Configuration writes take effect at once and belong to idle periods.
`timescale 1ns / 1ps
`default_nettype none

module adc_supply_monitor_filter #(
  parameter int unsigned AVG_LENGTH = 128
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // config write port
  input  wire logic                               cfg_we_i,
  input  wire logic [asmf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [31:0]                        cfg_wdata_i,
  // input frames
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire asmf_pkg::in_t                      in_data_i,
  // result frames
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output asmf_pkg::out_t                          out_data_o
);

  localparam int unsigned SLOT_W  = $clog2(AVG_LENGTH);
  localparam int unsigned HALF    = AVG_LENGTH / 2;
  localparam int unsigned RSUM_W  = 16 + $clog2(AVG_LENGTH);
  localparam int unsigned CSUM_W  = asmf_pkg::CUR_W + $clog2(AVG_LENGTH);
  localparam logic [RSUM_W-1:0] RSUM_RST = RSUM_W'(AVG_LENGTH * 3300);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_SUM    = 11'b000_0000_0010,
    S_AVG    = 11'b000_0000_0100,
    S_AVG_W  = 11'b000_0000_1000,
    S_VCC    = 11'b000_0001_0000,
    S_VCC_W  = 11'b000_0010_0000,
    S_MUL    = 11'b000_0100_0000,
    S_CSUM   = 11'b000_1000_0000,
    S_CAVG   = 11'b001_0000_0000,
    S_CAVG_W = 11'b010_0000_0000,
    S_DONE   = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Config registers
  logic [31:0] kvrefcal_q;
  logic [7:0]  vin_gain_q, vaux_gain_q, vcore_gain_q, cin_gain_q;

  // Control state
  logic [SLOT_W-1:0] slot_q;
  logic              filled_q;
  logic [RSUM_W-1:0] ref_sum_q;
  logic [CSUM_W-1:0] cur_sum_q;
  logic [1:0]        ch_q;
  logic              ph_q;
  logic              out_valid_q;

  // Working payload
  asmf_pkg::in_t                in_q;
  logic [15:0]                  cin_mag_q;
  logic [15:0]                  avg_q;
  logic [15:0]                  vcc_q, vin_q, vaux_q, vcore_q;
  logic [15:0]                  cin_q;
  logic [23:0]                  prod_q;
  logic [asmf_pkg::CUR_W-1:0]   cur_s_q;
  logic                         cneg_q;
  asmf_pkg::out_t               out_q;

  // Shared units
  asmf_pkg::div_req_t div_req;
  asmf_pkg::div_rsp_t div_rsp;
  logic [23:0]        mul_a;
  logic [15:0]        mul_b;
  logic [39:0]        mul_p;

  logic [15:0]                ref_old;
  logic [asmf_pkg::CUR_W-1:0] cur_old;

  logic in_acc, out_acc, out_load, slot_wrap;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign out_acc   = out_valid_q && !out_stall_i;
  assign out_load  = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  assign slot_wrap = (slot_q == SLOT_W'(AVG_LENGTH - 1));

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Config writes; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kvrefcal_q   <= asmf_pkg::KVREFCAL_RST;
      vin_gain_q   <= asmf_pkg::VIN_GAIN_RST;
      vaux_gain_q  <= asmf_pkg::VAUX_GAIN_RST;
      vcore_gain_q <= asmf_pkg::VCORE_GAIN_RST;
      cin_gain_q   <= asmf_pkg::CIN_GAIN_X4_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        asmf_pkg::CFG_KVREFCAL:    kvrefcal_q   <= cfg_wdata_i;
        asmf_pkg::CFG_VIN_GAIN:    vin_gain_q   <= cfg_wdata_i[7:0];
        asmf_pkg::CFG_VAUX_GAIN:   vaux_gain_q  <= cfg_wdata_i[7:0];
        asmf_pkg::CFG_VCORE_GAIN:  vcore_gain_q <= cfg_wdata_i[7:0];
        asmf_pkg::CFG_CIN_GAIN_X4: cin_gain_q   <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // History memories, both addressed by the shared slot
  asmf_hist #(
    .DEPTH   (AVG_LENGTH),
    .WIDTH   (16),
    .RST_VAL (asmf_pkg::NOMINAL_MV)
  ) u_ref_hist (
    .clk_i    (clk_i),
    .we_i     (state_q == S_SUM),
    .addr_i   (slot_q),
    .wdata_i  (in_q.vrefint_raw),
    .filled_i (filled_q),
    .rdata_o  (ref_old)
  );

  asmf_hist #(
    .DEPTH   (AVG_LENGTH),
    .WIDTH   (asmf_pkg::CUR_W),
    .RST_VAL ('0)
  ) u_cur_hist (
    .clk_i    (clk_i),
    .we_i     (state_q == S_CSUM),
    .addr_i   (slot_q),
    .wdata_i  (cur_s_q),
    .filled_i (filled_q),
    .rdata_o  (cur_old)
  );

  // Rounded current sum, split into sign and magnitude for the divider
  logic [CSUM_W:0] csum_rnd, csum_mag;
  assign csum_rnd = {cur_sum_q[CSUM_W-1], cur_sum_q} + (CSUM_W + 1)'(HALF);
  assign csum_mag = csum_rnd[CSUM_W] ? (~csum_rnd + 1'b1) : csum_rnd;

  // Divider request mux
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = asmf_pkg::DIV_W'(ref_sum_q) + asmf_pkg::DIV_W'(HALF);
    div_req.divisor  = asmf_pkg::DSR_W'(AVG_LENGTH);
    case (state_q)
      S_AVG: begin
        div_req.start = 1'b1;
      end
      S_VCC: begin
        div_req.start    = (avg_q != '0);
        div_req.dividend = kvrefcal_q;
        div_req.divisor  = avg_q;
      end
      S_CAVG: begin
        div_req.start    = 1'b1;
        div_req.dividend = asmf_pkg::DIV_W'(csum_mag);
      end
      default: ;
    endcase
  end

  asmf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Shared multiplier: phase 0 is raw * gain, phase 1 is that * vcc
  always_comb begin
    logic [15:0] raw_sel;
    logic [7:0]  gain_sel;
    case (ch_q)
      2'd0:    begin raw_sel = in_q.vin_raw;   gain_sel = vin_gain_q;   end
      2'd1:    begin raw_sel = in_q.vaux_raw;  gain_sel = vaux_gain_q;  end
      2'd2:    begin raw_sel = in_q.vcore_raw; gain_sel = vcore_gain_q; end
      default: begin raw_sel = cin_mag_q;      gain_sel = cin_gain_q;   end
    endcase
    if (ph_q) begin
      mul_a = prod_q;
      mul_b = vcc_q;
    end else begin
      mul_a = 24'(raw_sel);
      mul_b = 16'(gain_sel);
    end
  end
  assign mul_p = 40'(mul_a) * 40'(mul_b);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_acc) state_d = S_SUM;
      S_SUM:    state_d = S_AVG;
      S_AVG:    state_d = S_AVG_W;
      S_AVG_W:  if (div_rsp.done) state_d = S_VCC;
      S_VCC:    state_d = (avg_q == '0) ? S_MUL : S_VCC_W;
      S_VCC_W:  if (div_rsp.done) state_d = S_MUL;
      S_MUL:    if (ph_q && (ch_q == 2'd3)) state_d = S_CSUM;
      S_CSUM:   state_d = S_CAVG;
      S_CAVG:   state_d = S_CAVG_W;
      S_CAVG_W: if (div_rsp.done) state_d = S_DONE;
      S_DONE:   if (out_load) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Control registers and running sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      slot_q      <= '0;
      filled_q    <= 1'b0;
      ref_sum_q   <= RSUM_RST;
      cur_sum_q   <= '0;
      ch_q        <= '0;
      ph_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_SUM) begin
        ref_sum_q <= ref_sum_q - RSUM_W'(ref_old) + RSUM_W'(in_q.vrefint_raw);
      end
      if (state_q == S_CSUM) begin
        cur_sum_q <= cur_sum_q - CSUM_W'(signed'(cur_old)) + CSUM_W'(signed'(cur_s_q));
      end
      if (state_q == S_MUL) begin
        ph_q <= !ph_q;
        if (ph_q) ch_q <= ch_q + 1'b1;
      end
      if (out_load) begin
        slot_q      <= slot_wrap ? '0 : slot_q + 1'b1;
        filled_q    <= filled_q || slot_wrap;
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          in_q      <= in_data_i;
          cin_mag_q <= in_data_i.cin_raw[15] ? (~in_data_i.cin_raw + 1'b1)
                                             : in_data_i.cin_raw;
        end
      end
      S_AVG_W: begin
        if (div_rsp.done) avg_q <= div_rsp.quotient[15:0];
      end
      S_VCC: begin
        if (avg_q == '0) vcc_q <= asmf_pkg::NOMINAL_MV;
      end
      S_VCC_W: begin
        if (div_rsp.done) begin
          vcc_q <= (|div_rsp.quotient[31:16]) ? 16'hFFFF : div_rsp.quotient[15:0];
        end
      end
      S_MUL: begin
        if (!ph_q) begin
          prod_q <= mul_p[23:0];
        end else begin
          case (ch_q)
            2'd0: vin_q   <= (|mul_p[39:32]) ? 16'hFFFF : mul_p[31:16];
            2'd1: vaux_q  <= (|mul_p[39:32]) ? 16'hFFFF : mul_p[31:16];
            2'd2: vcore_q <= (|mul_p[39:32]) ? 16'hFFFF : mul_p[31:16];
            default: begin
              // truncation toward zero: scale the magnitude, then restore sign
              cur_s_q <= in_q.cin_raw[15] ? (~mul_p[39:18] + 1'b1) : mul_p[39:18];
            end
          endcase
        end
      end
      S_CAVG: begin
        cneg_q <= csum_rnd[CSUM_W];
      end
      S_CAVG_W: begin
        if (div_rsp.done) begin
          if (cneg_q) begin
            cin_q <= (div_rsp.quotient > 32'd32768) ? 16'h8000
                                                    : (~div_rsp.quotient[15:0] + 1'b1);
          end else begin
            cin_q <= (div_rsp.quotient > 32'd32767) ? 16'h7FFF : div_rsp.quotient[15:0];
          end
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_q.vcc_mv   <= vcc_q;
      out_q.vin_mv   <= vin_q;
      out_q.vaux_mv  <= vaux_q;
      out_q.vcore_mv <= vcore_q;
      out_q.cin_ma   <= cin_q;
    end
  end

  // A frame transaction always starts a sum update next cycle
  a_acc_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_SUM)
    else $error("accepted frame did not enter the sum step");

  // The divider is idle whenever the sequencer is outside its divide steps
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) || (state_q == S_MUL) || (state_q == S_DONE) |-> !div_rsp.busy)
    else $error("divider busy outside a divide step");

  // Finishing a frame advances the slot by one, with wrap
  a_slot_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q &&
      (slot_q == (($past(slot_q) == SLOT_W'(AVG_LENGTH - 1)) ? '0 : $past(slot_q) + 1'b1)))
    else $error("slot or output valid wrong after a frame completed");

endmodule

`default_nettype wire
